// ===== design/lbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_pkg
// shared types and codes of the lru block cache
// ----------------------------------------------------------------------------
package lbc_pkg;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_OFF     = 2'd2,
    ST_DUP     = 2'd3
  } status_t;

  localparam logic CFG_ENABLE  = 1'b0;
  localparam logic CFG_ENTRIES = 1'b1;

  localparam int unsigned CFG_W = 7;

endpackage

// ===== design/lru_block_cache_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_block_cache_core
// fully associative lru block cache, tags scanned by one compare unit
// ----------------------------------------------------------------------------
// a lookup or run start answers after its input transfer, once the scan has
// read the entries in use, one registered tag read and compare per cycle
// a hit then streams its words from the block memory, each read in S_RD and
// sent from S_STR, which holds while the output is stalled
// throughput: one item at a time, taken only while idle with no result pending
// reset: synchronous, clears valid bits, counters, clock and run state

module lru_block_cache_core import lbc_pkg::*; #(
  parameter int unsigned ENTRIES         = 64,
  parameter int unsigned WORDS_PER_BLOCK = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_disk,
  input  logic [7:0]  in_block_number,
  input  logic [4:0]  in_word_index,
  input  logic [63:0] in_word_data,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_word_data_res,
  output logic [4:0]  out_word_index_res,
  output logic        out_last,
  output logic [31:0] out_query_count,
  output logic [31:0] out_hit_count,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned WW = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
  localparam int unsigned AW = IW + WW;
  localparam int unsigned DEPTH = ENTRIES * WORDS_PER_BLOCK;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_DEC  = 7'b0000100,
    S_RD   = 7'b0001000,
    S_STR  = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_WR   = 7'b1000000
  } state_t;

  state_t state_r;

  logic              en_r;
  logic [6:0]        eiu_r;
  logic [ENTRIES-1:0] valid_r;
  logic [3:0]        dtag   [ENTRIES];
  logic [7:0]        btag   [ENTRIES];
  logic [31:0]       atime  [ENTRIES];
  logic [63:0]       mem    [DEPTH];
  logic [31:0]       clock_r, q_r, h_r;
  logic [IW-1:0]     run_slot_r;
  logic [1:0]        run_mode_r;

  logic [1:0]        kind_r;
  logic [3:0]        disk_r;
  logic [7:0]        blk_r;
  logic [4:0]        wi_r;
  logic [63:0]       data_r;
  logic              lastw_r;

  logic              ov_r;
  logic [1:0]        ost_r;
  logic [63:0]       owd_r;
  logic [4:0]        owi_r;
  logic              olast_r;
  logic [WW:0]       wcnt_r;
  logic [IW-1:0]     slot_r;
  logic [63:0]       rd_r;

  // active entry count saturated to 2..ENTRIES
  logic [IW:0] limit;
  always_comb begin
    if (eiu_r < 7'd2) limit = (IW+1)'(2);
    else if ({{(IW > 6 ? IW-6 : 0){1'b0}}, eiu_r} > (IW > 6 ? IW+1 : 7)'(ENTRIES))
      limit = (IW+1)'(ENTRIES);
    else limit = (IW+1)'(eiu_r);
  end

  logic          sc_start, sc_done, sc_hit, sc_free;
  logic [IW-1:0] sc_idx, sc_hit_idx, sc_free_idx, sc_lru_idx;

  // registered read of the tag table at the scan address
  logic          ent_valid_r;
  logic [3:0]    ent_disk_r;
  logic [7:0]    ent_blk_r;
  logic [31:0]   ent_time_r;
  always_ff @(posedge clk) begin
    ent_valid_r <= valid_r[sc_idx];
    ent_disk_r  <= dtag[sc_idx];
    ent_blk_r   <= btag[sc_idx];
    ent_time_r  <= atime[sc_idx];
  end

  lbc_scan #(.IW(IW)) u_scan (
    .clk(clk), .rst_n(rst_n), .start(sc_start), .limit(limit),
    .disk(disk_r), .blk(blk_r), .idx(sc_idx),
    .ent_valid(ent_valid_r), .ent_disk(ent_disk_r), .ent_blk(ent_blk_r),
    .ent_time(ent_time_r), .done(sc_done), .hit(sc_hit), .hit_idx(sc_hit_idx),
    .free(sc_free), .free_idx(sc_free_idx), .lru_idx(sc_lru_idx)
  );

  logic in_fire, out_fire;
  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = ov_r && out_ready;
  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_word_data_res = owd_r;
  assign out_word_index_res = owi_r;
  assign out_last = olast_r;
  assign out_query_count = q_r;
  assign out_hit_count = h_r;

  logic [IW-1:0] ins_slot;
  assign ins_slot = sc_free ? sc_free_idx : sc_lru_idx;

  // memory write and read ports
  logic          mwe;
  logic [AW-1:0] mwa, mra;
  logic [63:0]   mwd;
  always_ff @(posedge clk) begin
    if (mwe) mem[mwa] <= mwd;
    rd_r <= mem[mra];
  end
  assign mra = {slot_r, wcnt_r[WW-1:0]};

  logic word_ok;
  assign word_ok = (32'(wi_r) < WORDS_PER_BLOCK);

  always_comb begin
    mwe = 1'b0;
    mwa = {run_slot_r, wi_r[WW-1:0]};
    mwd = data_r;
    if (state_r == S_WR && en_r && run_mode_r == kind_r && word_ok)
      mwe = 1'b1;
    if (state_r == S_DEC && en_r && sc_done) begin
      if (kind_r == KIND_INSERT && !sc_hit) begin
        mwe = 1'b1;
        mwa = {ins_slot, {WW{1'b0}}};
      end else if (kind_r == KIND_UPDATE && sc_hit) begin
        mwe = 1'b1;
        mwa = {sc_hit_idx, {WW{1'b0}}};
      end
    end
  end

  assign sc_start = (state_r == S_IDLE) && in_fire && en_r &&
                    (in_kind == KIND_LOOKUP ||
                     ((in_kind == KIND_INSERT || in_kind == KIND_UPDATE) &&
                      in_word_index == 5'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      en_r <= 1'b0;
      eiu_r <= 7'(ENTRIES);
      valid_r <= '0;
      clock_r <= '0;
      q_r <= '0;
      h_r <= '0;
      run_slot_r <= '0;
      run_mode_r <= KIND_LOOKUP;
      ov_r <= 1'b0;
      wcnt_r <= '0;
    end else begin
      if (out_fire && state_r != S_STR) ov_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_ENABLE) begin
          en_r <= cfg_data[0];
          if (!cfg_data[0]) begin
            valid_r <= '0;
            clock_r <= '0;
            run_mode_r <= KIND_LOOKUP;
          end
        end else begin
          eiu_r <= cfg_data;
        end
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            kind_r <= in_kind; disk_r <= in_disk; blk_r <= in_block_number;
            wi_r <= in_word_index; data_r <= in_word_data; lastw_r <= in_last_word;
            ost_r <= ST_OFF; owd_r <= '0; owi_r <= '0; olast_r <= 1'b1;
            if (in_kind == KIND_NONE) begin
              state_r <= S_IDLE;
            end else if (in_kind != KIND_LOOKUP && in_word_index != 5'd0) begin
              state_r <= S_WR;
            end else begin
              if (in_kind != KIND_LOOKUP) run_mode_r <= KIND_LOOKUP;
              if (!en_r) ov_r <= 1'b1;
              else state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: state_r <= S_DEC;
        S_DEC: begin
          if (sc_done) begin
            case (kind_r)
              KIND_LOOKUP: begin
                q_r <= q_r + 1'b1;
                if (sc_hit) begin
                  h_r <= h_r + 1'b1;
                  clock_r <= clock_r + 1'b1;
                  atime[sc_hit_idx] <= clock_r + 1'b1;
                  slot_r <= sc_hit_idx;
                  wcnt_r <= '0;
                  state_r <= S_RD;
                end else begin
                  ov_r <= 1'b1;
                  ost_r <= ST_MISS;
                  state_r <= S_IDLE;
                end
              end
              KIND_INSERT: begin
                ov_r <= 1'b1;
                state_r <= S_IDLE;
                if (sc_hit) ost_r <= ST_DUP;
                else begin
                  ost_r <= ST_OK;
                  valid_r[ins_slot] <= 1'b1;
                  dtag[ins_slot] <= disk_r;
                  btag[ins_slot] <= blk_r;
                  clock_r <= clock_r + 1'b1;
                  atime[ins_slot] <= clock_r + 1'b1;
                  run_slot_r <= ins_slot;
                  run_mode_r <= lastw_r ? KIND_LOOKUP : KIND_INSERT;
                end
              end
              default: begin
                ov_r <= 1'b1;
                state_r <= S_IDLE;
                if (!sc_hit) ost_r <= ST_MISS;
                else begin
                  ost_r <= ST_OK;
                  clock_r <= clock_r + 1'b1;
                  atime[sc_hit_idx] <= clock_r + 1'b1;
                  run_slot_r <= sc_hit_idx;
                  run_mode_r <= lastw_r ? KIND_LOOKUP : KIND_UPDATE;
                end
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_STR;
        end
        S_STR: begin
          if (!ov_r || out_ready) begin
            ov_r <= 1'b1;
            ost_r <= ST_OK;
            owd_r <= rd_r;
            owi_r <= 5'(wcnt_r[WW-1:0]);
            olast_r <= (32'(wcnt_r) == WORDS_PER_BLOCK - 1);
            if (32'(wcnt_r) == WORDS_PER_BLOCK - 1) begin
              state_r <= S_OUT;
            end else begin
              wcnt_r <= wcnt_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        S_OUT: state_r <= S_IDLE;
        S_WR: begin
          if (en_r && run_mode_r == kind_r && lastw_r) run_mode_r <= KIND_LOOKUP;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("ready while busy");
  a_hitcnt: assert property (@(posedge clk) disable iff (!rst_n)
    (h_r != $past(h_r)) |-> (q_r != $past(q_r)))
    else $error("hit without query");

endmodule

// ===== design/lbc_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_scan
// shared compare unit: walks the tag table one entry per cycle, comparing the
// registered table read in the cycle after its address, finding the first tag
// match, the first free slot and the least recently used entry
// ----------------------------------------------------------------------------
module lbc_scan import lbc_pkg::*; #(
  parameter int unsigned IW      = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [IW:0]   limit,
  input  logic [3:0]    disk,
  input  logic [7:0]    blk,
  output logic [IW-1:0] idx,
  input  logic          ent_valid,
  input  logic [3:0]    ent_disk,
  input  logic [7:0]    ent_blk,
  input  logic [31:0]   ent_time,
  output logic          done,
  output logic          hit,
  output logic [IW-1:0] hit_idx,
  output logic          free,
  output logic [IW-1:0] free_idx,
  output logic [IW-1:0] lru_idx
);

  logic          busy_r;
  logic [IW:0]   cnt_r;
  logic          pend_r;
  logic [IW-1:0] pend_idx_r;
  logic          hit_r, free_r;
  logic [IW-1:0] hit_idx_r, free_idx_r, lru_idx_r;
  logic [31:0]   lru_time_r;
  logic          first_r;

  assign idx      = cnt_r[IW-1:0];
  assign done     = busy_r && (cnt_r == limit) && !pend_r;
  assign hit      = hit_r;
  assign hit_idx  = hit_idx_r;
  assign free     = free_r;
  assign free_idx = free_idx_r;
  assign lru_idx  = lru_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      first_r <= 1'b0;
    end else if (start) begin
      busy_r  <= 1'b1;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
      first_r <= 1'b1;
    end else if (busy_r) begin
      // address stage
      if (cnt_r != limit) begin
        cnt_r      <= cnt_r + 1'b1;
        pend_r     <= 1'b1;
        pend_idx_r <= idx;
      end else begin
        pend_r <= 1'b0;
        if (!pend_r) busy_r <= 1'b0;
      end
      // compare stage on the registered entry
      if (pend_r) begin
        first_r <= 1'b0;
        if (!hit_r && ent_valid && ent_disk == disk && ent_blk == blk) begin
          hit_r     <= 1'b1;
          hit_idx_r <= pend_idx_r;
        end
        if (!free_r && !ent_valid) begin
          free_r     <= 1'b1;
          free_idx_r <= pend_idx_r;
        end
        if (first_r || ent_time < lru_time_r) begin
          lru_time_r <= ent_time;
          lru_idx_r  <= pend_idx_r;
        end
      end
    end
  end

endmodule
